// File: rtl/smoothstep_position_interpolator_unit_macros.svh
// Assertion macros for the smoothstep position interpolator.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef SMOOTHSTEP_POSITION_INTERPOLATOR_UNIT_MACROS_SVH
`define SMOOTHSTEP_POSITION_INTERPOLATOR_UNIT_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent
`define SPI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent
`define SPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/spi_pkg.sv
// Shared types and constants of the smoothstep position interpolator.
// No dependencies; used by the top, the divider and the port checker.
package spi_pkg;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_STALE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_BASE   = 2'd0,
    REG_SPEED  = 2'd1,
    REG_MARGIN = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_TICK_USER,
    S_TICK_CHK,
    S_DUR1,
    S_DUR2,
    S_DUR3,
    S_STEP,
    S_DIV,
    S_SM1,
    S_SM2,
    S_SM3,
    S_BX,
    S_BY,
    S_RESP
  } fsm_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [2:0]         user_index;
    logic [15:0]        packet_number;
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic [15:0]        time_step;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic               known;
  } out_t;

  typedef struct packed {
    logic [15:0]        number;
    logic signed [23:0] x;
    logic signed [23:0] y;
  } qent_t;

  typedef struct packed {
    logic        start;
    logic [23:0] num;
    logic [23:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quot;
  } div_rsp_t;

  localparam int unsigned QENT_W = $bits(qent_t);

  localparam logic [15:0]        BASE_RST   = 16'd50000;
  localparam logic [15:0]        SPEED_RST  = 16'd256;
  localparam logic [15:0]        MARGIN_RST = 16'd0;
  localparam logic signed [16:0] LAST_NONE  = -17'sd1;
  localparam logic [16:0]        ONE16      = 17'h10000;
  localparam logic [17:0]        THREE16    = 18'd196608;
  localparam logic [23:0]        DUR_MAX    = 24'hFFFFFF;
  localparam logic signed [51:0] RND_HALF   = 52'sd32768;

endpackage

// File: rtl/smoothstep_position_interpolator_unit.sv
// Smoothstep position interpolator: top level, sequencer and per-user state.
// Depends on spi_pkg, spi_ram, spi_mul and spi_div.
//
// Channel | Dir | Handshake              | Beat
// in      | in  | in_valid_i/in_ready_o  | spi_pkg::in_t (add, tick, read)
// out     | out | out_valid_o/out_ready_i| spi_pkg::out_t, one per input beat
// cfg     | in  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// Add, read and unused opcodes pass through S_EXEC and S_RESP. A tick visits
// every user in turn, drops stale queue heads and, per step on a segment, runs
// the shared bit-serial divider; a step that opens a segment first sets its duration.
// The queue RAM needs no clearing; the block is ready right after reset.
// A stalled result stays in the output register; the sequencer waits on it.
module smoothstep_position_interpolator_unit #(
  parameter int USERS       = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  spi_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output spi_pkg::out_t  out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [15:0]    cfg_data_i
);

  localparam int QW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int UW    = (USERS > 1) ? $clog2(USERS) : 1;
  localparam int UCW   = $clog2(USERS + 1);
  localparam int DEPTH = USERS * QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  // Configuration
  logic [15:0] base_q, speed_q, margin_q;

  // Per-user state
  logic [QW-1:0]      head_q  [USERS];
  logic [CW-1:0]      count_q [USERS];
  logic signed [16:0] last_q  [USERS];
  logic signed [23:0] cur_x_q [USERS];
  logic signed [23:0] cur_y_q [USERS];
  logic signed [23:0] sx_q    [USERS];
  logic signed [23:0] sy_q    [USERS];
  logic [23:0]        el_q    [USERS];
  logic [23:0]        dur_q   [USERS];
  logic [USERS-1:0]   seen_q;

  // Sequencer and item registers
  spi_pkg::fsm_e      state_q, state_d;
  logic [UCW-1:0]     u_q;
  logic               uok_q;
  logic [1:0]         op_q;
  logic [15:0]        num_q;
  logic signed [23:0] tx_q, ty_q;
  logic [15:0]        dt_q, rem_q;
  logic [16:0]        s_q;
  spi_pkg::out_t      res_d, res_q, out_q;
  logic               out_valid_q;

  logic [UW-1:0] ui;
  assign ui = u_q[UW-1:0];

  // Shared units
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [spi_pkg::QENT_W-1:0] ram_rdata;
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] mul_p;
  spi_pkg::div_req_t  div_req;
  spi_pkg::div_rsp_t  div_rsp;

  spi_ram #(.WIDTH(spi_pkg::QENT_W), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({num_q, tx_q, ty_q}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  spi_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  spi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Add path: a first add restarts the user before the queue checks
  logic               add_new, add_stale, add_full, add_write;
  logic signed [16:0] add_last;
  logic [QW-1:0]      add_head, add_slot;
  logic [CW-1:0]      add_cnt;
  logic [QW:0]        slot_sum;

  assign add_new   = !seen_q[ui];
  assign add_last  = add_new ? spi_pkg::LAST_NONE : last_q[ui];
  assign add_head  = add_new ? '0 : head_q[ui];
  assign add_cnt   = add_new ? '0 : count_q[ui];
  assign add_stale = $signed({1'b0, num_q}) <= add_last;
  assign add_full  = add_cnt >= CW'(QUEUE_DEPTH);
  assign slot_sum  = (QW+1)'(add_head) + (QW+1)'(add_cnt);
  assign add_slot  = (slot_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                     QW'(slot_sum - (QW+1)'(QUEUE_DEPTH)) : slot_sum[QW-1:0];
  assign add_write = (spi_pkg::op_e'(op_q) == spi_pkg::OP_ADD) && uok_q &&
                     !add_stale && !add_full;

  // Tick path: queue head, segment timing and smoothstep terms
  spi_pkg::qent_t     ent;
  logic signed [16:0] ent_num;
  logic               ent_stale, tick_done, tick_work, seg_close;
  logic [16:0]        gap;
  logic [QW-1:0]      head_inc;
  logic [23:0]        need, step, el_new, dur_new;
  logic [40:0]        dur_raw;
  logic [16:0]        t_w;
  logic [17:0]        f_w;
  logic signed [24:0] diff_x, diff_y;
  logic signed [51:0] blend_rnd;
  logic signed [23:0] delta;

  assign ent       = spi_pkg::qent_t'(ram_rdata);
  assign ent_num   = $signed({1'b0, ent.number});
  assign ent_stale = ent_num <= last_q[ui];
  assign gap       = last_q[ui][16] ? 17'd1 : 17'(ent_num - last_q[ui]);
  assign head_inc  = (head_q[ui] == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q[ui] + 1'b1;
  assign tick_done = u_q == UCW'(USERS);
  assign tick_work = seen_q[ui] && (rem_q != 16'd0) && (count_q[ui] != '0);

  assign need    = dur_q[ui] - el_q[ui];
  assign step    = (need < {8'd0, rem_q}) ? need : {8'd0, rem_q};
  assign el_new  = el_q[ui] + step;
  assign dur_raw = mul_p[48:8];
  assign dur_new = (dur_raw == '0) ? 24'd1 :
                   ((|dur_raw[40:24]) ? spi_pkg::DUR_MAX : dur_raw[23:0]);

  assign t_w       = (div_rsp.quot > spi_pkg::ONE16) ? spi_pkg::ONE16 : div_rsp.quot;
  assign f_w       = spi_pkg::THREE16 - {t_w, 1'b0};
  assign diff_x    = 25'(ent.x) - 25'(sx_q[ui]);
  assign diff_y    = 25'(ent.y) - 25'(sy_q[ui]);
  assign blend_rnd = mul_p + spi_pkg::RND_HALF;
  assign delta     = blend_rnd[39:16];
  assign seg_close = ({1'b0, el_q[ui]} + 25'(margin_q)) >= {1'b0, dur_q[ui]};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      spi_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (spi_pkg::op_e'(in_data_i.opcode) == spi_pkg::OP_TICK) ?
                    spi_pkg::S_TICK_USER : spi_pkg::S_EXEC;
        end
      end
      spi_pkg::S_EXEC: state_d = spi_pkg::S_RESP;
      spi_pkg::S_TICK_USER: begin
        if (tick_done) begin
          state_d = spi_pkg::S_RESP;
        end else if (tick_work) begin
          state_d = spi_pkg::S_TICK_CHK;
        end
      end
      spi_pkg::S_TICK_CHK: begin
        if (ent_stale) begin
          state_d = spi_pkg::S_TICK_USER;
        end else if (dur_q[ui] == 24'd0) begin
          state_d = spi_pkg::S_DUR1;
        end else begin
          state_d = spi_pkg::S_STEP;
        end
      end
      spi_pkg::S_DUR1: state_d = spi_pkg::S_DUR2;
      spi_pkg::S_DUR2: state_d = spi_pkg::S_DUR3;
      spi_pkg::S_DUR3: state_d = spi_pkg::S_STEP;
      spi_pkg::S_STEP: state_d = spi_pkg::S_DIV;
      spi_pkg::S_DIV: begin
        if (div_rsp.done) begin
          state_d = spi_pkg::S_SM1;
        end
      end
      spi_pkg::S_SM1: state_d = spi_pkg::S_SM2;
      spi_pkg::S_SM2: state_d = spi_pkg::S_SM3;
      spi_pkg::S_SM3: state_d = spi_pkg::S_BX;
      spi_pkg::S_BX:  state_d = spi_pkg::S_BY;
      spi_pkg::S_BY:  state_d = spi_pkg::S_TICK_USER;
      spi_pkg::S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = spi_pkg::S_IDLE;
        end
      end
      default: state_d = spi_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: memory, multiplier and divider controls
  always_comb begin
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = AW'(32'(ui) * QUEUE_DEPTH + 32'(add_slot));
    ram_raddr   = AW'(32'(ui) * QUEUE_DEPTH + 32'(head_q[ui]));
    mul_a       = '0;
    mul_b       = '0;
    div_req.start = 1'b0;
    div_req.num   = el_new;
    div_req.den   = dur_q[ui];
    case (state_q)
      spi_pkg::S_EXEC:      ram_we = add_write;
      spi_pkg::S_TICK_USER: ram_re = !tick_done && tick_work;
      spi_pkg::S_DUR1: begin
        mul_a = $signed({17'd0, gap});
        mul_b = $signed({2'd0, base_q});
      end
      spi_pkg::S_DUR2: begin
        mul_a = $signed({1'b0, mul_p[32:0]});
        mul_b = $signed({2'd0, speed_q});
      end
      spi_pkg::S_STEP: div_req.start = 1'b1;
      spi_pkg::S_SM1: begin
        mul_a = $signed({17'd0, t_w});
        mul_b = $signed({1'b0, t_w});
      end
      spi_pkg::S_SM2: begin
        mul_a = $signed({16'd0, f_w});
        mul_b = $signed({1'b0, mul_p[32:16]});
      end
      spi_pkg::S_SM3: begin
        mul_a = 34'(diff_x);
        mul_b = $signed({1'b0, mul_p[32:16]});
      end
      spi_pkg::S_BX: begin
        mul_a = 34'(diff_y);
        mul_b = $signed({1'b0, s_q});
      end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spi_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= spi_pkg::BASE_RST;
      speed_q  <= spi_pkg::SPEED_RST;
      margin_q <= spi_pkg::MARGIN_RST;
    end else if (cfg_valid_i) begin
      case (spi_pkg::reg_e'(cfg_index_i))
        spi_pkg::REG_BASE:   base_q   <= cfg_data_i;
        spi_pkg::REG_SPEED:  speed_q  <= cfg_data_i;
        spi_pkg::REG_MARGIN: margin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Item registers, user pointer and tick budget
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q <= '0;
    end else begin
      case (state_q)
        spi_pkg::S_IDLE: begin
          if (in_valid_i) begin
            u_q <= (spi_pkg::op_e'(in_data_i.opcode) == spi_pkg::OP_TICK) ?
                   '0 : UCW'(in_data_i.user_index);
          end
        end
        spi_pkg::S_TICK_USER: begin
          if (!tick_done && !tick_work) begin
            u_q <= u_q + 1'b1;
          end
        end
        spi_pkg::S_BY: begin
          if (!seg_close) begin
            u_q <= u_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      spi_pkg::S_IDLE: begin
        if (in_valid_i) begin
          uok_q <= 32'(in_data_i.user_index) < USERS;
          op_q  <= in_data_i.opcode;
          num_q <= in_data_i.packet_number;
          tx_q  <= in_data_i.target_x;
          ty_q  <= in_data_i.target_y;
          dt_q  <= in_data_i.time_step;
          rem_q <= in_data_i.time_step;
        end
      end
      spi_pkg::S_TICK_USER: begin
        if (!tick_done && !tick_work) begin
          rem_q <= dt_q;
        end
      end
      spi_pkg::S_STEP: rem_q <= 16'(24'(rem_q) - step);
      spi_pkg::S_SM3:  s_q <= mul_p[32:16];
      spi_pkg::S_BY: begin
        if (!seg_close) begin
          rem_q <= dt_q;
        end
      end
      default: ;
    endcase
  end

  // Result of the item: status for adds, position for reads, zero otherwise
  always_comb begin
    res_d = '0;
    if (state_q == spi_pkg::S_EXEC) begin
      case (spi_pkg::op_e'(op_q))
        spi_pkg::OP_ADD: begin
          if (uok_q && add_stale) begin
            res_d.status = spi_pkg::ST_STALE;
          end else if (uok_q && add_full) begin
            res_d.status = spi_pkg::ST_FULL;
          end
        end
        spi_pkg::OP_READ: begin
          if (uok_q && seen_q[ui]) begin
            res_d.pos_x = cur_x_q[ui];
            res_d.pos_y = cur_y_q[ui];
            res_d.known = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == spi_pkg::S_EXEC || (state_q == spi_pkg::S_TICK_USER && tick_done)) begin
      res_q <= res_d;
    end
  end

  // Per-user state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      for (int i = 0; i < USERS; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
        last_q[i]  <= spi_pkg::LAST_NONE;
        cur_x_q[i] <= '0;
        cur_y_q[i] <= '0;
        sx_q[i]    <= '0;
        sy_q[i]    <= '0;
        el_q[i]    <= '0;
        dur_q[i]   <= '0;
      end
    end else begin
      case (state_q)
        spi_pkg::S_EXEC: begin
          if (spi_pkg::op_e'(op_q) == spi_pkg::OP_ADD && uok_q) begin
            if (add_new) begin
              seen_q[ui]  <= 1'b1;
              last_q[ui]  <= spi_pkg::LAST_NONE;
              cur_x_q[ui] <= tx_q;
              cur_y_q[ui] <= ty_q;
              sx_q[ui]    <= tx_q;
              sy_q[ui]    <= ty_q;
              el_q[ui]    <= '0;
              dur_q[ui]   <= '0;
              head_q[ui]  <= '0;
            end
            count_q[ui] <= add_write ? add_cnt + 1'b1 : add_cnt;
          end
        end
        spi_pkg::S_TICK_CHK: begin
          if (ent_stale) begin
            head_q[ui]  <= head_inc;
            count_q[ui] <= count_q[ui] - 1'b1;
          end
        end
        spi_pkg::S_DUR3: begin
          dur_q[ui] <= dur_new;
          el_q[ui]  <= '0;
          sx_q[ui]  <= cur_x_q[ui];
          sy_q[ui]  <= cur_y_q[ui];
        end
        spi_pkg::S_STEP: el_q[ui] <= el_new;
        spi_pkg::S_BX:   cur_x_q[ui] <= sx_q[ui] + delta;
        spi_pkg::S_BY: begin
          cur_y_q[ui] <= sy_q[ui] + delta;
          if (seg_close) begin
            last_q[ui]  <= ent_num;
            head_q[ui]  <= head_inc;
            count_q[ui] <= count_q[ui] - 1'b1;
            el_q[ui]    <= '0;
            dur_q[ui]   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: load a result once the previous beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == spi_pkg::S_RESP && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == spi_pkg::S_RESP && (!out_valid_q || out_ready_i)) begin
      out_q <= res_q;
    end
  end

  assign in_ready_o  = state_q == spi_pkg::S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

// File: rtl/spi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/spi_mul.sv
// Shared signed multiplier with a registered product.
// No package dependency.
module spi_mul (
  input  logic               clk_i,
  input  logic signed [33:0] a_i,
  input  logic signed [17:0] b_i,
  output logic signed [51:0] p_o
);

  logic signed [51:0] p_q;

  // Register the product for the next sequencer step
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// File: rtl/spi_div.sv
// Radix-2 restoring divider: quot = (num << 16) / den, with num <= den.
// Depends on spi_pkg for the request and response structs.
module spi_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spi_pkg::div_req_t req_i,
  output spi_pkg::div_rsp_t rsp_o
);

  logic [23:0] rem_q;
  logic [23:0] den_q;
  logic [16:0] quot_q;
  logic [4:0]  cnt_q;
  logic        lsb_q;
  logic        busy_q;
  logic        done_q;
  logic [24:0] trial;
  logic        fits;

  // Shift in the numerator's low bit once, zeros after that
  assign trial = {rem_q, (cnt_q == 5'd16) ? lsb_q : 1'b0};
  assign fits  = trial >= {1'b0, den_q};

  // Control: one quotient bit per cycle, seventeen in all
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !req_i.start && busy_q && (cnt_q == 5'd0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd16;
      end else if (busy_q) begin
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  // Datapath: remainder and quotient
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= {1'b0, req_i.num[23:1]};
      lsb_q  <= req_i.num[0];
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? 24'(trial - {1'b0, den_q}) : trial[23:0];
      quot_q <= {quot_q[15:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// File: rtl/spi_chk.sv
// Port checker for the smoothstep position interpolator, bound to the top.
// Depends on spi_pkg and the assertion macro header.
`include "smoothstep_position_interpolator_unit_macros.svh"

module spi_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input spi_pkg::out_t out_data_o
);

  // Hold a stalled result beat
  `SPI_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result beat dropped or changed while stalled")

  // Drop ready after taking an input beat
  `SPI_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "input taken while an item is in work")

  // A known position only comes from a read, which reports ok
  `SPI_ASSERT_SAME(a_known_ok, out_valid_o && out_data_o.known, out_data_o.status == spi_pkg::ST_OK, "known result with nonzero status")

  // Unknown results carry a zero position
  `SPI_ASSERT_SAME(a_unknown_zero, out_valid_o && !out_data_o.known, out_data_o.pos_x == 24'sd0 && out_data_o.pos_y == 24'sd0, "position on a result without a known user")

endmodule

bind smoothstep_position_interpolator_unit spi_chk u_spi_chk (.*);
